>>> sv/fcpm_pkg.sv
`timescale 1ns / 1ps

package fcpm_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS = 16;

  // Quotient magnitude holds values up to 2.0 in fixed point.
  localparam int QW = FRAC_BITS + 2;
  localparam int XW = QW + 1;
  localparam int KW = 11;
  localparam int TW = FRAC_BITS + 13;
  localparam int LATENCY = FRAC_BITS + 5;

  localparam logic [1:0] REG_PALETTE = 2'd0;
  localparam logic [1:0] REG_LOW = 2'd1;
  localparam logic [1:0] REG_HIGH = 2'd2;

  typedef enum logic [1:0] {
    PAL_RAINBOW = 2'd0,
    PAL_GRAY    = 2'd1,
    PAL_AFMHOT  = 2'd2
  } palette_t;

  localparam logic signed [KW-1:0] K_RAINBOW = 11'sd1020;
  localparam logic signed [KW-1:0] K_AFMHOT = 11'sd510;
  localparam logic signed [KW-1:0] K_GRAY = 11'sd255;

  localparam logic [SAMPLE_WIDTH-1:0] HIGH_RESET = SAMPLE_WIDTH'(1) << FRAC_BITS;
  localparam logic [QW-1:0] Q_SAT = QW'(2) << FRAC_BITS;

  localparam logic signed [TW-1:0] C_127 = TW'(127) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_133 = TW'(133) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_389 = TW'(389) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_392 = TW'(392) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_640 = TW'(640) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_644 = TW'(644) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_900 = TW'(900) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_1155 = TW'(1155) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_255 = TW'(255) << FRAC_BITS;
  localparam logic signed [TW-1:0] C_HALF_255 = TW'(255) << (FRAC_BITS - 1);

  typedef struct packed {
    logic                    neg;
    logic                    sat;
    logic                    deg;
    logic                    bright;
    palette_t                pal;
    logic [QW-1:0]           q;
    logic [SAMPLE_WIDTH-1:0] r;
    logic [SAMPLE_WIDTH-1:0] d;
  } div_t;

  function automatic logic signed [TW-1:0] smin(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [TW-1:0] smax(input logic signed [TW-1:0] a,
                                                 input logic signed [TW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Truncate the fraction and clamp to the 8-bit channel range.
  function automatic logic [7:0] chan(input logic signed [TW-1:0] v);
    logic [TW-FRAC_BITS-1:0] u;
    u = v[TW-1:FRAC_BITS];
    if (v <= 0) begin
      return 8'd0;
    end else if (u > (TW-FRAC_BITS)'(255)) begin
      return 8'd255;
    end
    return u[7:0];
  endfunction

endpackage

>>> sv/fcpm_front.sv
`timescale 1ns / 1ps

module fcpm_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [fcpm_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic [fcpm_pkg::SAMPLE_WIDTH-1:0] range_low,
  input  logic [fcpm_pkg::SAMPLE_WIDTH-1:0] range_high,
  input  fcpm_pkg::palette_t               pal,
  output logic                             out_valid,
  output fcpm_pkg::div_t                   out_data
);
  import fcpm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic                 a_valid;
  logic signed [SW:0]   a_num;
  logic [SW:0]          a_den;
  logic                 a_deg;
  logic                 a_bright;
  palette_t             a_pal;

  logic                 b_valid;
  logic [SW-1:0]        b_n;
  logic [SW-1:0]        b_d;
  logic                 b_neg;
  logic                 b_deg;
  logic                 b_bright;
  palette_t             b_pal;

  logic signed [SW:0]   s_ext;
  logic signed [SW:0]   lo_ext;
  logic signed [SW:0]   hi_ext;
  logic signed [SW:0]   num_abs;
  logic                 ge_two;
  logic                 ge_one;

  assign s_ext = $signed({sample[SW-1], sample});
  assign lo_ext = $signed({range_low[SW-1], range_low});
  assign hi_ext = $signed({range_high[SW-1], range_high});
  assign num_abs = a_num[SW] ? -a_num : a_num;
  assign ge_two = {1'b0, b_n} >= {b_d, 1'b0};
  assign ge_one = b_n >= b_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_num <= s_ext - lo_ext;
    a_den <= hi_ext - lo_ext;
    a_deg <= hi_ext <= lo_ext;
    a_bright <= s_ext > hi_ext;
    a_pal <= pal;

    b_n <= num_abs[SW-1:0];
    b_d <= a_den[SW-1:0];
    b_neg <= a_num[SW];
    b_deg <= a_deg;
    b_bright <= a_bright;
    b_pal <= a_pal;

    out_data.neg <= b_neg;
    out_data.sat <= ge_two;
    out_data.deg <= b_deg;
    out_data.bright <= b_bright;
    out_data.pal <= b_pal;
    out_data.q <= QW'(ge_one);
    out_data.r <= ge_one ? (b_n - b_d) : b_n;
    out_data.d <= b_d;
  end

endmodule

>>> sv/fcpm_frac_step.sv
`timescale 1ns / 1ps

module fcpm_frac_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  fcpm_pkg::div_t in_data,
  output logic           out_valid,
  output fcpm_pkg::div_t out_data
);
  import fcpm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic [SW:0] r2;
  logic [SW:0] diff;
  logic        ge;
  div_t        out_next;

  assign r2 = {in_data.r, 1'b0};
  assign diff = r2 - {1'b0, in_data.d};
  assign ge = r2 >= {1'b0, in_data.d};

  always_comb begin
    out_next = in_data;
    out_next.q = {in_data.q[QW-2:0], ge};
    out_next.r = ge ? diff[SW-1:0] : r2[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_next;
  end

endmodule

>>> sv/fcpm_color.sv
`timescale 1ns / 1ps

module fcpm_color (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  fcpm_pkg::div_t in_data,
  output logic           out_valid,
  output logic [7:0]     red,
  output logic [7:0]     green,
  output logic [7:0]     blue
);
  import fcpm_pkg::*;

  logic                   d_valid;
  logic signed [TW-1:0]   d_t;
  logic                   d_deg;
  logic                   d_bright;
  palette_t               d_pal;

  logic [QW-1:0]          x_mag;
  logic signed [XW-1:0]   x_s;
  logic signed [KW-1:0]   kmul;
  logic signed [XW+KW-1:0] prod;

  logic signed [TW-1:0]   rb_r;
  logic signed [TW-1:0]   rb_g;
  logic signed [TW-1:0]   rb_b;
  logic [7:0]             r_val;
  logic [7:0]             g_val;
  logic [7:0]             b_val;

  assign x_mag = in_data.sat ? Q_SAT : in_data.q;
  assign x_s = in_data.neg ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
  assign prod = x_s * kmul;

  always_comb begin
    unique case (in_data.pal)
      PAL_GRAY:   kmul = K_GRAY;
      PAL_AFMHOT: kmul = K_AFMHOT;
      default:    kmul = K_RAINBOW;
    endcase
  end

  assign rb_r = smin(d_t - C_389, C_1155 - d_t);
  assign rb_g = smax(smin(d_t - C_133, C_644 - d_t), smin(d_t - C_392, C_900 - d_t));
  assign rb_b = smin(d_t + C_127, C_640 - d_t);

  always_comb begin
    if (d_deg) begin
      r_val = d_bright ? 8'd255 : 8'd0;
      g_val = r_val;
      b_val = r_val;
    end else begin
      unique case (d_pal)
        PAL_GRAY: begin
          r_val = chan(d_t);
          g_val = r_val;
          b_val = r_val;
        end
        PAL_AFMHOT: begin
          r_val = chan(d_t);
          g_val = chan(d_t - C_HALF_255);
          b_val = chan(d_t - C_255);
        end
        default: begin
          r_val = chan(rb_r);
          g_val = chan(rb_g);
          b_val = chan(rb_b);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      d_valid <= in_valid;
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_t <= prod[TW-1:0];
    d_deg <= in_data.deg;
    d_bright <= in_data.bright;
    d_pal <= in_data.pal;
    red <= r_val;
    green <= g_val;
    blue <= b_val;
  end

endmodule

>>> sv/false_color_palette_map_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         start (busy low)     sample
// config    in         cfg_write            cfg_addr, cfg_wdata
// result    out        done, one cycle      red, green, blue
//
// One sample enters every clock cycle; busy is always low.
// Each result passes through the front end, the divider stages and the colour
// stage; the divider resolves one quotient bit per pipeline stage.
// Reset clears every pipeline valid bit and loads the register defaults.
// The result side cannot stall, so the pipeline advances on every cycle.

module false_color_palette_map_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fcpm_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_addr,
  input  logic [fcpm_pkg::SAMPLE_WIDTH-1:0] cfg_wdata,
  output logic                              done,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue
);
  import fcpm_pkg::*;

  palette_t                palette_select;
  logic [SAMPLE_WIDTH-1:0] range_low;
  logic [SAMPLE_WIDTH-1:0] range_high;

  logic                    stage_valid [FRAC_BITS+1];
  div_t                    stage_data [FRAC_BITS+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_select <= PAL_RAINBOW;
      range_low <= '0;
      range_high <= HIGH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_addr)
        REG_PALETTE: palette_select <= palette_t'(cfg_wdata[1:0]);
        REG_LOW:     range_low <= cfg_wdata;
        REG_HIGH:    range_high <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  fcpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .sample    (sample),
    .range_low (range_low),
    .range_high(range_high),
    .pal       (palette_select),
    .out_valid (stage_valid[0]),
    .out_data  (stage_data[0])
  );

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_frac
    fcpm_frac_step u_step (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[i]),
      .in_data  (stage_data[i]),
      .out_valid(stage_valid[i+1]),
      .out_data (stage_data[i+1])
    );
  end

  fcpm_color u_color (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[FRAC_BITS]),
    .in_data  (stage_data[FRAC_BITS]),
    .out_valid(done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("accepted beat did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result produced without a matching input beat");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    stage_valid[0] |-> stage_data[0].sat || stage_data[0].deg ||
      stage_data[0].r < stage_data[0].d)
    else $error("divider remainder not below divisor");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fcpm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam logic [1:0] PAL_SPARE = 2'd3;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint UNIT = 64'sd1 <<< FRAC_BITS;
  localparam int STALL_LIMIT = 1000;
  localparam int RAND_SETS = 26;
  localparam int ITEMS_PER_SET = 50;

  typedef struct packed {
    logic [SW-1:0] smp;
    logic [7:0]    red;
    logic [7:0]    green;
    logic [7:0]    blue;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t expected_q[$];
    int mismatches;

    function longint lmin(longint a, longint b);
      return (a < b) ? a : b;
    endfunction

    function longint lmax(longint a, longint b);
      return (a > b) ? a : b;
    endfunction

    function logic [7:0] to_channel(longint v);
      longint u;
      if (v <= 0) begin
        return 8'd0;
      end
      u = v >>> FRAC_BITS;
      if (u > 255) begin
        return 8'd255;
      end
      return u[7:0];
    endfunction

    // For high > low, x = (sample - low) / (high - low) in fixed point, magnitude
    // truncated and held to 2.0, then each channel is a ramp or a min/max of ramps.
    function void note_sample(logic [SW-1:0] smp, logic [1:0] pal,
                              logic [SW-1:0] lo_raw, logic [SW-1:0] hi_raw);
      longint s, lo, hi, num, den, mag, x, t;
      pixel_t px;
      s = longint'($signed(smp));
      lo = longint'($signed(lo_raw));
      hi = longint'($signed(hi_raw));
      px.smp = smp;
      if (hi <= lo) begin
        px.red = (s > hi) ? 8'd255 : 8'd0;
        px.green = px.red;
        px.blue = px.red;
      end else begin
        num = s - lo;
        den = hi - lo;
        mag = (num < 0) ? -num : num;
        if (mag >= 2 * den) begin
          mag = 2 * UNIT;
        end else begin
          mag = (mag <<< FRAC_BITS) / den;
        end
        x = (num < 0) ? -mag : mag;
        if (pal == PAL_GRAY) begin
          px.red = to_channel(255 * x);
          px.green = px.red;
          px.blue = px.red;
        end else if (pal == PAL_AFMHOT) begin
          t = 510 * x;
          px.red = to_channel(t);
          px.green = to_channel(t - ((255 * UNIT) >>> 1));
          px.blue = to_channel(t - 255 * UNIT);
        end else begin
          t = 1020 * x;
          px.red = to_channel(lmin(t - 389 * UNIT, 1155 * UNIT - t));
          px.green = to_channel(lmax(lmin(t - 133 * UNIT, 644 * UNIT - t),
                                     lmin(t - 392 * UNIT, 900 * UNIT - t)));
          px.blue = to_channel(lmin(t + 127 * UNIT, 640 * UNIT - t));
        end
      end
      expected_q.push_back(px);
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      pixel_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected pixel %0d/%0d/%0d", r, g, b);
        end
        return;
      end
      want = expected_q.pop_front();
      if (want.red !== r || want.green !== g || want.blue !== b) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("pixel mismatch for sample %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                   $signed(want.smp), want.red, want.green, want.blue, r, g, b);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [SW-1:0] sample = '0;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [SW-1:0] cfg_wdata = '0;
  logic busy;
  logic done;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  logic [1:0] cur_palette;
  logic [SW-1:0] cur_low;
  logic [SW-1:0] cur_high;
  int idle_cycles = 0;
  pixel_scoreboard sb;

  false_color_palette_map_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .cfg_write(cfg_write),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .done(done),
    .red(red),
    .green(green),
    .blue(blue)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      cur_palette <= PAL_RAINBOW;
      cur_low <= '0;
      cur_high <= HIGH_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_addr)
          REG_PALETTE: begin
            cur_palette <= cfg_wdata[1:0];
          end
          REG_LOW: begin
            cur_low <= cfg_wdata;
          end
          REG_HIGH: begin
            cur_high <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (start && !busy) begin
        sb.note_sample(sample, cur_palette, cur_low, cur_high);
      end
      if (done) begin
        sb.check_pixel(red, green, blue);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [SW-1:0] fit32(longint v);
    longint c;
    c = v;
    if (c > S32_MAX) begin
      c = S32_MAX;
    end else if (c < S32_MIN) begin
      c = S32_MIN;
    end
    return c[SW-1:0];
  endfunction

  function automatic longint rand_s32();
    logic [31:0] raw;
    raw = $urandom;
    return longint'($signed(raw));
  endfunction

  // Most samples land around the scale so every ramp segment is hit; some
  // fall far outside it and some are raw random words.
  function automatic logic [SW-1:0] pick_sample(longint lo, longint hi);
    longint span, s;
    int kind;
    span = hi - lo;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      s = rand_s32();
    end else if (span <= 0) begin
      s = hi + longint'($urandom_range(0, 4)) - 2;
    end else if (kind < 5) begin
      s = ((kind == 3) ? lo : hi) + longint'($urandom_range(0, 6)) - 3;
    end else if (kind < 9) begin
      s = lo + span * (longint'($urandom_range(0, 20000)) - 10000) / 4000;
    end else begin
      s = lo + span * longint'($urandom_range(0, 4000)) / 4000
          + longint'($urandom_range(0, 3));
    end
    return fit32(s);
  endfunction

  task automatic write_reg(input logic [1:0] addr, input logic [SW-1:0] data);
    cfg_write <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [1:0] pal, input longint lo, input longint hi);
    logic [SW-1:0] pal_word;
    pal_word = $urandom;
    pal_word[1:0] = pal;
    write_reg(REG_PALETTE, pal_word);
    write_reg(REG_LOW, fit32(lo));
    write_reg(REG_HIGH, fit32(hi));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_NONE, $urandom);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic random_config(output logic [1:0] pal, output longint lo,
                               output longint hi);
    longint tmp;
    int kind;
    pal = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 11);
    if (kind == 0) begin
      lo = rand_s32();
      hi = rand_s32();
      if (hi > lo) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
    end else if (kind == 1) begin
      lo = S32_MIN;
      hi = S32_MAX;
    end else if (kind == 2) begin
      lo = rand_s32();
      hi = lo;
    end else if (kind < 7) begin
      lo = longint'($urandom_range(0, 2097152)) - 1048576;
      hi = lo + longint'($urandom_range(1, 4096));
    end else if (kind < 10) begin
      lo = rand_s32();
      hi = lo + longint'($urandom_range(65536, 16777216));
      if (hi > S32_MAX) begin
        hi = S32_MAX;
      end
    end else begin
      lo = rand_s32();
      hi = rand_s32();
      if (lo > hi) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
    end
  endtask

  task automatic send_item(input logic [SW-1:0] value, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    sample <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0] pal;
    longint lo, hi;
    int idle_pct;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset scale 0..1.0 with the rainbow palette.
    send_item(fit32(0), 0);
    send_item(fit32(32768), 0);
    send_item(fit32(65536), 20);
    send_item(fit32(65535), 0);
    send_item(fit32(25000), 20);
    send_item(fit32(131072), 0);
    send_item(fit32(131071), 0);
    send_item(fit32(-131072), 20);
    send_item(fit32(-65536), 0);
    send_item(fit32(S32_MAX), 0);
    send_item(fit32(S32_MIN), 20);
    send_item(fit32(-1), 0);
    drain();

    // Grayscale with junk in the upper palette bits, full-width scale, and
    // a write to the unused register index that must change nothing.
    write_reg(REG_PALETTE, 32'hFFFF_FFFD);
    write_reg(REG_LOW, fit32(S32_MIN));
    write_reg(REG_HIGH, fit32(S32_MAX));
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    cfg_write <= 1'b0;
    send_item(fit32(S32_MIN), 0);
    send_item(fit32(S32_MAX), 0);
    send_item(fit32(0), 0);
    drain();

    apply_config(PAL_AFMHOT, -1000, 1000);
    send_item(fit32(-1000), 0);
    send_item(fit32(0), 20);
    send_item(fit32(1000), 0);
    send_item(fit32(5000), 0);
    drain();

    // Empty scale with the spare palette code, then an inverted one.
    apply_config(PAL_SPARE, 100, 100);
    send_item(fit32(100), 0);
    send_item(fit32(101), 0);
    send_item(fit32(-5), 0);
    drain();

    apply_config(PAL_RAINBOW, S32_MAX, S32_MIN);
    send_item(fit32(S32_MIN), 0);
    send_item(fit32(S32_MAX), 0);
    drain();

    for (int set_idx = 0; set_idx < RAND_SETS; set_idx++) begin
      random_config(pal, lo, hi);
      apply_config(pal, lo, hi);
      if (set_idx >= RAND_SETS - 4) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      repeat (ITEMS_PER_SET) send_item(pick_sample(lo, hi), idle_pct);
      drain();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> false_color_palette_map_unit.f
sv/fcpm_pkg.sv
sv/fcpm_front.sv
sv/fcpm_frac_step.sv
sv/fcpm_color.sv
sv/false_color_palette_map_unit.sv
sim/tb_top.sv
